### hdl/skvt_pkg.sv
// Package for the sorted keyed value table: operation and status codes,
// and the entry and command types shared by the cell row and the top level.
// No dependencies.
package skvt_pkg;

   localparam int ValueWidth    = 32;
   localparam int TagWidth      = 32;
   localparam int PositionWidth = 6;
   localparam int OpcodeWidth   = 2;
   localparam int StatusWidth   = 2;
   localparam int OccWidth      = 7;

   typedef enum logic [OpcodeWidth-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_NOKEY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic signed [TagWidth-1:0]   tag;
   } entry_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type item;
   } cmd_type;

endpackage

### hdl/skvt_ifs.sv
// Handshake channels of the sorted keyed value table: request and response.
// Depends on skvt_pkg.
interface skvt_req_if;
   import skvt_pkg::*;

   logic                              valid;
   logic                              ready;
   logic [OpcodeWidth-1:0]            opcode;
   logic signed [ValueWidth-1:0]      sort_value;
   logic signed [TagWidth-1:0]        tag;
   logic [PositionWidth-1:0]          position;

   modport source (output valid, opcode, sort_value, tag, position, input ready);
   modport sink   (input valid, opcode, sort_value, tag, position, output ready);
endinterface

interface skvt_rsp_if;
   import skvt_pkg::*;

   logic                              valid;
   logic                              ready;
   logic signed [ValueWidth-1:0]      read_value;
   logic [StatusWidth-1:0]            status;
   logic [OccWidth-1:0]               occupancy;

   modport source (output valid, read_value, status, occupancy, input ready);
   modport sink   (input valid, read_value, status, occupancy, output ready);
endinterface

### hdl/skvt_cell.sv
// One cell of the sorted row: holds one value/tag entry and shifts it to or
// from its neighbors on insert and remove. Depends on skvt_pkg.
module skvt_cell (
   input  logic               clock,
   input  skvt_pkg::cmd_type  cmd,
   input  logic               occupied,
   input  logic               lt_left,
   input  logic               seen_left,
   input  skvt_pkg::entry_type left_entry,
   input  skvt_pkg::entry_type right_entry,
   output logic               lt_out,
   output logic               seen_out,
   output skvt_pkg::entry_type entry
);
   import skvt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      match;

   // Cells holding a value below the new one form a prefix of the row.
   assign lt_out   = occupied && (entry_ff.value < cmd.item.value);
   assign match    = occupied && (entry_ff.tag == cmd.item.tag);
   assign seen_out = seen_left || match;
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins && !lt_out) begin
         entry_in = lt_left ? cmd.item : left_entry;
      end else if (cmd.rem && seen_out) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### hdl/sorted_keyed_value_table_unit.sv
// Sorted keyed value table: a row of cells holding value/tag pairs in
// ascending order of value. Depends on skvt_pkg, skvt_ifs and skvt_cell.
//
// The response to an accepted request is registered in the cycle after it.
// Throughput: one item per cycle unless a response waits untaken; every cell
// compares against the broadcast item and shifts in one step, and the response
// register empties as it fills. Reset clears the entry count and the response
// valid flag; cell contents are left as they are, since only cells below the count are ever read.
module sorted_keyed_value_table_unit #(
   parameter int CAPACITY = 64
) (
   input logic          clock,
   input logic          reset,
   skvt_req_if.sink     req_chan,
   skvt_rsp_if.source   rsp_chan
);
   import skvt_pkg::*;

   // Count width holds CAPACITY itself; the compare widths cover both the
   // count and the position and occupancy fields.
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int PW  = (CW > PositionWidth) ? CW : PositionWidth;
   localparam int OCW = (CW > OccWidth) ? CW : OccWidth;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [ValueWidth-1:0] rsp_value_ff;
   logic signed [ValueWidth-1:0] rsp_value_in;
   status_type                   rsp_status_ff;
   status_type                   rsp_status_in;
   logic [OccWidth-1:0]          rsp_occ_ff;
   logic [OccWidth-1:0]          rsp_occ_in;

   logic       accept;
   opcode_type op;
   logic       full;
   logic       found;
   logic       in_range;
   cmd_type    cmd;

   logic [PW-1:0]  pos_wide;
   logic [OCW-1:0] count_wide;

   logic      lt_chain   [CAPACITY+1];
   logic      seen_chain [CAPACITY+1];
   entry_type cell_entry [CAPACITY];
   logic signed [ValueWidth-1:0] sel_value;

   // The request side stalls only while a response waits and is not taken.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign op             = opcode_type'(req_chan.opcode);

   assign full     = (count_ff == CW'(CAPACITY));
   assign pos_wide = PW'(req_chan.position);
   assign in_range = (pos_wide < PW'(count_ff));
   assign found    = seen_chain[CAPACITY];

   always_comb begin
      cmd.ins        = accept && (op == OP_INSERT) && !full;
      cmd.rem        = accept && (op == OP_REMOVE);
      cmd.item.value = req_chan.sort_value;
      cmd.item.tag   = req_chan.tag;
   end

   // The left edge of the row behaves as a cell below every value, and
   // no match has been seen before the first cell.
   assign lt_chain[0]   = 1'b1;
   assign seen_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_entry = cmd.item;
      end else begin : g_inner_left
         assign left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_inner_right
         assign right_entry = cell_entry[i+1];
      end

      skvt_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CW'(i) < count_ff),
         .lt_left     (lt_chain[i]),
         .seen_left   (seen_chain[i]),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .lt_out      (lt_chain[i+1]),
         .seen_out    (seen_chain[i+1]),
         .entry       (cell_entry[i])
      );
   end

   // The read picks one cell by position through an AND-OR select.
   always_comb begin
      sel_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos_wide == PW'(i)) begin
            sel_value = sel_value | cell_entry[i].value;
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = ST_OK;
         unique case (op)
            OP_INSERT: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            OP_REMOVE: begin
               if (found) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  rsp_status_in = ST_NOKEY;
               end
            end
            OP_READ: begin
               if (in_range) begin
                  rsp_value_in = sel_value;
               end else begin
                  rsp_status_in = ST_RANGE;
               end
            end
            default: begin
               // The unused code changes nothing and reports success.
            end
         endcase
      end
   end

   // Without an accepted item the next count equals the current one, which is
   // also what the response register already reports.
   assign count_wide = OCW'(count_in);
   assign rsp_occ_in = count_wide[OccWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.occupancy  = rsp_occ_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_INSERT) && !full |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the table");

   a_nokey_keeps: assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_REMOVE) && !found |=> $stable(count_ff))
      else $error("failed remove changed the count");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && (rsp_occ_ff == OccWidth'(OCW'(count_ff))))
      else $error("response missing or occupancy wrong");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> rsp_value_ff == '0)
      else $error("failed operation returned a value");
`endif

endmodule
